FILE: design/lge_pkg.sv
// shared types, codes and the cell rule of the life grid engine
package lge_pkg;

  // widest grid side is 64, so row and column codes fit in 6 bits
  localparam int unsigned COORD_W = 6;

  typedef enum logic [1:0] {
    MODE_TOGGLE = 2'd0,
    MODE_STEP   = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  typedef enum logic {
    WR_TOGGLE = 1'b0,
    WR_LIFE   = 1'b1
  } wr_src_t;

  typedef struct packed {
    logic               rd_en;
    logic [COORD_W-1:0] rd_addr;
    logic               wr_en;
    logic [COORD_W-1:0] wr_addr;
    wr_src_t            wr_src;
    logic [COORD_W-1:0] tog_col;
    logic               win_shift;
    logic               win_save0;
    logic               win_wrap;
    logic               res_load;
    logic               res_read;
  } lge_cmd_t;

  // conway rule: three neighbours give life, two keep the cell as it is
  function automatic logic next_cell(input logic [7:0] nb, input logic self);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(nb[i]);
    end
    return (n == 4'd3) || ((n == 4'd2) && self);
  endfunction

endpackage

FILE: design/lge_ctrl.sv
// controller state machine of the life grid engine
module lge_ctrl #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    mode,
  input  logic [lge_pkg::COORD_W-1:0]   col,
  input  logic [lge_pkg::COORD_W-1:0]   row,
  output logic                          busy,
  output logic                          done,
  output logic                          status,
  output lge_pkg::lge_cmd_t             cmd
);

  localparam int CW   = $clog2(GRID_HEIGHT + 3);
  localparam int LAST = GRID_HEIGHT + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_TOG_RD,
    S_TOG_WR,
    S_RD,
    S_RESP
  } state_t;

  state_t                        state;
  logic [CW-1:0]                 cnt;
  logic [lge_pkg::COORD_W-1:0]   col_q;
  logic [lge_pkg::COORD_W-1:0]   row_q;
  logic                          fail;
  logic                          read_q;
  logic                          col_ok;
  logic                          row_ok;

  assign col_ok = {1'b0, col} < 7'(GRID_WIDTH);
  assign row_ok = {1'b0, row} < 7'(GRID_HEIGHT);
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      fail   <= 1'b0;
      read_q <= 1'b0;
      done   <= 1'b0;
      status <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            col_q  <= col;
            row_q  <= row;
            cnt    <= '0;
            fail   <= 1'b0;
            read_q <= 1'b0;
            unique case (lge_pkg::mode_t'(mode))
              lge_pkg::MODE_TOGGLE: begin
                if (col_ok && row_ok) begin
                  state <= S_TOG_RD;
                end else begin
                  fail  <= 1'b1;
                  state <= S_RESP;
                end
              end
              lge_pkg::MODE_STEP: begin
                state <= S_STEP;
              end
              lge_pkg::MODE_READ: begin
                if (row_ok) begin
                  read_q <= 1'b1;
                  state  <= S_RD;
                end else begin
                  fail  <= 1'b1;
                  state <= S_RESP;
                end
              end
              default: begin
                fail  <= 1'b1;
                state <= S_RESP;
              end
            endcase
          end
        end
        S_STEP: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(LAST)) begin
            state <= S_RESP;
          end
        end
        S_TOG_RD: begin
          state <= S_TOG_WR;
        end
        S_TOG_WR: begin
          state <= S_RESP;
        end
        S_RD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          done   <= 1'b1;
          status <= fail;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // step sweep: read last row, then rows 0..h-1; row r is written once row r+1 is in
  always_comb begin
    cmd           = '0;
    cmd.rd_addr   = row_q;
    cmd.wr_addr   = row_q;
    cmd.tog_col   = col_q;
    cmd.wr_src    = lge_pkg::WR_TOGGLE;
    cmd.res_read  = read_q;
    unique case (state)
      S_STEP: begin
        cmd.wr_src    = lge_pkg::WR_LIFE;
        cmd.rd_en     = (cnt <= CW'(GRID_HEIGHT));
        cmd.rd_addr   = (cnt == '0) ? lge_pkg::COORD_W'(GRID_HEIGHT - 1)
                                    : lge_pkg::COORD_W'(cnt - CW'(1));
        cmd.win_shift = (cnt >= CW'(1)) && (cnt <= CW'(GRID_HEIGHT + 1));
        cmd.win_save0 = (cnt == CW'(2));
        cmd.wr_en     = (cnt >= CW'(3));
        cmd.wr_addr   = lge_pkg::COORD_W'(cnt - CW'(3));
        cmd.win_wrap  = (cnt == CW'(LAST));
      end
      S_TOG_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_TOG_WR: begin
        cmd.wr_en = 1'b1;
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_RESP: begin
        cmd.res_load = 1'b1;
      end
      default: begin
        cmd.rd_en = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/lge_dp.sv
// datapath of the life grid engine: row memory, three-row window and cell logic
module lge_dp #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  lge_pkg::lge_cmd_t cmd,
  output logic [31:0]       row_bits
);

  localparam int AW = $clog2(GRID_HEIGHT);

  logic [GRID_WIDTH-1:0]  mem [GRID_HEIGHT];
  logic [GRID_HEIGHT-1:0] vld;
  logic [GRID_WIDTH-1:0]  mem_q;
  logic                   vld_q;
  logic [GRID_WIDTH-1:0]  rdata;
  logic [GRID_WIDTH-1:0]  prev;
  logic [GRID_WIDTH-1:0]  cur;
  logic [GRID_WIDTH-1:0]  save0;
  logic [GRID_WIDTH-1:0]  dn;
  logic [GRID_WIDTH-1:0]  life;
  logic [GRID_WIDTH-1:0]  tog_mask;
  logic [GRID_WIDTH-1:0]  wdata;
  logic [63:0]            rdata_ext;

  // rows never written since reset read as dead
  assign rdata     = vld_q ? mem_q : '0;
  assign dn        = cmd.win_wrap ? save0 : rdata;
  assign tog_mask  = GRID_WIDTH'(1) << cmd.tog_col;
  assign wdata     = (cmd.wr_src == lge_pkg::WR_LIFE) ? life : (rdata ^ tog_mask);
  assign rdata_ext = 64'(rdata);

  for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_cell
    localparam int LF = (c + GRID_WIDTH - 1) % GRID_WIDTH;
    localparam int RT = (c + 1) % GRID_WIDTH;
    assign life[c] = lge_pkg::next_cell({prev[LF], prev[c], prev[RT],
                                         cur[LF], cur[RT],
                                         dn[LF], dn[c], dn[RT]}, cur[c]);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[AW-1:0]] <= wdata;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[cmd.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        vld[cmd.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (cmd.rd_en) begin
        vld_q <= vld[cmd.rd_addr[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_shift) begin
      prev <= cur;
      cur  <= rdata;
    end
    if (cmd.win_save0) begin
      save0 <= rdata;
    end
    if (cmd.res_load) begin
      row_bits <= cmd.res_read ? rdata_ext[31:0] : 32'd0;
    end
  end

endmodule

FILE: design/life_grid_engine_top.sv
// top level of the life grid engine
// A toroidal game of life grid, GRID_WIDTH columns by GRID_HEIGHT rows,
// each side held within 3..64.
// A request is taken at a rising edge with start high and busy low; mode,
// col and row are sampled there. Mode toggle flips one cell, step advances
// one generation, read returns one row on row_bits (bit n is column n).
// Every request gives exactly one result: done is high for one cycle with
// row_bits and status valid in that cycle. status is 1 when a coordinate
// that the mode uses is out of range (toggle: col and row, read: row) or
// the mode is unused; nothing changes then. busy drops in the done cycle,
// so the next request can be taken at the edge that ends it. A step is one
// sweep of the single-read, single-write row memory: the last row, then
// every row in turn, with each new row written as soon as the row below it
// has been read. The receiver cannot stall; a result is shown once only.
// Reset clears the grid at once (per-row valid bits) and leaves the block idle.
module life_grid_engine_top #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [5:0]  col,
  input  logic [5:0]  row,
  output logic        done,
  output logic [31:0] row_bits,
  output logic        status
);

  localparam int GW = (GRID_WIDTH < 3) ? 3 : ((GRID_WIDTH > 64) ? 64 : GRID_WIDTH);
  localparam int GH = (GRID_HEIGHT < 3) ? 3 : ((GRID_HEIGHT > 64) ? 64 : GRID_HEIGHT);

  lge_pkg::lge_cmd_t cmd;

  lge_ctrl #(
    .GRID_WIDTH  (GW),
    .GRID_HEIGHT (GH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .col    (col),
    .row    (row),
    .busy   (busy),
    .done   (done),
    .status (status),
    .cmd    (cmd)
  );

  lge_dp #(
    .GRID_WIDTH  (GW),
    .GRID_HEIGHT (GH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .row_bits (row_bits)
  );

endmodule

FILE: tb/tb_life_grid_engine_top.sv
// self-checking testbench for the toroidal life grid engine
module tb_life_grid_engine_top;

  localparam int GRID_W = 32;
  localparam int GRID_H = 32;
  localparam int RANDOM_TARGET = 1175;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] mode;
    logic [5:0] col;
    logic [5:0] row;
    bit         drain;  // hold the request back until every result is in
  } req_t;

  typedef struct {
    logic [31:0] row_bits;
    logic        status;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  mode = lge_pkg::MODE_TOGGLE;
  logic [5:0]  col = '0;
  logic [5:0]  row = '0;
  logic        busy;
  logic        done;
  logic [31:0] row_bits;
  logic        status;

  req_t     pending_reqs[$];
  outcome_t expected_outcomes[$];
  bit [63:0] grid [64];
  int n_predicted = 0;
  int n_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;

  life_grid_engine_top #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .mode    (mode),
    .col     (col),
    .row     (row),
    .done    (done),
    .row_bits(row_bits),
    .status  (status)
  );

  always #4 clk = ~clk;

  // one generation over a snapshot, edges wrap round
  function automatic void life_generation();
    bit [63:0] prev [64];
    int up, dn, lf, rt, n;
    prev = grid;
    for (int r = 0; r < GRID_H; r++) begin
      up = (r + GRID_H - 1) % GRID_H;
      dn = (r + 1) % GRID_H;
      for (int c = 0; c < GRID_W; c++) begin
        lf = (c + GRID_W - 1) % GRID_W;
        rt = (c + 1) % GRID_W;
        n = int'(prev[up][lf]) + int'(prev[up][c]) + int'(prev[up][rt])
          + int'(prev[r][lf]) + int'(prev[r][rt])
          + int'(prev[dn][lf]) + int'(prev[dn][c]) + int'(prev[dn][rt]);
        grid[r][c] = (n == 3) || ((n == 2) && prev[r][c]);
      end
    end
  endfunction

  function automatic outcome_t life_apply(req_t q);
    outcome_t o;
    o.row_bits = '0;
    o.status = 1'b0;
    case (q.mode)
      lge_pkg::MODE_TOGGLE: begin
        if (q.col < GRID_W && q.row < GRID_H) grid[q.row][q.col] = ~grid[q.row][q.col];
        else o.status = 1'b1;
      end
      lge_pkg::MODE_STEP: life_generation();
      lge_pkg::MODE_READ: begin
        if (q.row < GRID_H) o.row_bits = grid[q.row][31:0];
        else o.status = 1'b1;
      end
      default: o.status = 1'b1;
    endcase
    return o;
  endfunction

  task automatic add_req(input int m, input int c, input int r,
                         input bit hold = 1'b0);
    req_t q;
    q.mode = 2'(m);
    q.col = 6'(c);
    q.row = 6'(r);
    q.drain = hold;
    pending_reqs.push_back(q);
  endtask

  // driver: predicts each request as it is taken, then presents the next
  req_t cur;
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    bit go;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_outcomes.push_back(life_apply(cur));
        n_predicted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].drain || n_checked == n_predicted)) begin
          go = 1'b1;
          cur = pending_reqs.pop_front();
          mode <= cur.mode;
          col <= cur.col;
          row <= cur.row;
          if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
          end else if ($urandom_range(0, 24) == 0) begin
            burst_left = $urandom_range(10, 30);
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(0, 3);
          end
        end
        start <= go;
      end
    end
  end

  // monitor: every done strobe is matched against the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: row_bits %h status %0d", row_bits, status);
      end else begin
        want = expected_outcomes.pop_front();
        if (row_bits !== want.row_bits || status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on request %0d: row_bits exp %h got %h, status exp %0d got %0d",
                     n_checked, want.row_bits, row_bits, want.status, status);
        end
        n_checked <= n_checked + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int cx, cy, n;
    // corners, edges and out of range codes
    add_req(lge_pkg::MODE_TOGGLE, 0, 0);
    add_req(lge_pkg::MODE_TOGGLE, GRID_W - 1, GRID_H - 1);
    add_req(lge_pkg::MODE_TOGGLE, GRID_W - 1, 0);
    add_req(lge_pkg::MODE_TOGGLE, 0, GRID_H - 1);
    add_req(lge_pkg::MODE_READ, 0, 0);
    add_req(lge_pkg::MODE_READ, 63, GRID_H - 1);
    add_req(lge_pkg::MODE_TOGGLE, GRID_W, 0);
    add_req(lge_pkg::MODE_TOGGLE, 63, 63);
    add_req(lge_pkg::MODE_TOGGLE, 5, GRID_H);
    add_req(lge_pkg::MODE_READ, 0, GRID_H);
    add_req(lge_pkg::MODE_READ, 0, 63);
    add_req(MODE_UNUSED, 63, 63);
    // the four corners make a block across the wrap, so it survives
    add_req(lge_pkg::MODE_STEP, 63, 63);
    add_req(lge_pkg::MODE_READ, 0, 0);
    add_req(lge_pkg::MODE_READ, 0, GRID_H - 1);
    add_req(lge_pkg::MODE_TOGGLE, 0, 0, 1'b1);
    // blinker
    add_req(lge_pkg::MODE_TOGGLE, 10, 5);
    add_req(lge_pkg::MODE_TOGGLE, 11, 5);
    add_req(lge_pkg::MODE_TOGGLE, 12, 5);
    add_req(lge_pkg::MODE_STEP, 0, 0);
    add_req(lge_pkg::MODE_READ, 0, 4);
    add_req(lge_pkg::MODE_READ, 0, 5);
    add_req(lge_pkg::MODE_READ, 0, 6);
    add_req(lge_pkg::MODE_STEP, 0, 0);
    add_req(lge_pkg::MODE_READ, 0, 5);

    // rounds of seeding a patch, a few generations and reads near it
    while (pending_reqs.size() < RANDOM_TARGET) begin
      if ($urandom_range(0, 2) != 0) cx = $urandom_range(0, GRID_W - 1);
      else cx = $urandom_range(0, 1) ? 0 : GRID_W - 1;
      if ($urandom_range(0, 2) != 0) cy = $urandom_range(0, GRID_H - 1);
      else cy = $urandom_range(0, 1) ? 0 : GRID_H - 1;
      n = $urandom_range(3, 12);
      for (int k = 0; k < n; k++)
        add_req(lge_pkg::MODE_TOGGLE, (cx + $urandom_range(0, 4) + GRID_W - 2) % GRID_W,
                (cy + $urandom_range(0, 4) + GRID_H - 2) % GRID_H,
                k == 0 && $urandom_range(0, 14) == 0);
      repeat ($urandom_range(1, 4))
        add_req(lge_pkg::MODE_STEP, $urandom_range(0, 63), $urandom_range(0, 63));
      repeat ($urandom_range(3, 8))
        add_req(lge_pkg::MODE_READ, $urandom_range(0, 63),
                (cy + $urandom_range(0, 6) + GRID_H - 3) % GRID_H);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3))
          add_req($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || n_checked != n_predicted);
    repeat (GRID_H + 10) @(negedge clk);

    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
